// ===== rtl/esk_pkg.sv =====
// ----------------------------------------------------------------------------
// esk_pkg
// Shared types, byte constants, key codes and lookup functions for the
// terminal escape sequence key decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package esk_pkg;

  // Field widths.
  localparam int unsigned ByteW = 8;
  localparam int unsigned KeyW  = 9;

  // Bytes that steer the sequence parser.
  localparam logic [ByteW-1:0] ByteEsc     = 8'h1B;
  localparam logic [ByteW-1:0] ByteTilde   = 8'h7E;
  localparam logic [ByteW-1:0] ByteBracket = 8'h5B;
  localparam logic [ByteW-1:0] ByteLetterO = 8'h4F;
  localparam logic [ByteW-1:0] ByteZero    = 8'h30;
  localparam logic [ByteW-1:0] ByteNine    = 8'h39;
  localparam logic [ByteW-1:0] ByteOne     = 8'h31;
  localparam logic [ByteW-1:0] ByteTwo     = 8'h32;
  localparam logic [ByteW-1:0] ByteThree   = 8'h33;
  localparam logic [ByteW-1:0] ByteFour    = 8'h34;
  localparam logic [ByteW-1:0] ByteFive    = 8'h35;
  localparam logic [ByteW-1:0] ByteSix     = 8'h36;
  localparam logic [ByteW-1:0] ByteSeven   = 8'h37;
  localparam logic [ByteW-1:0] ByteEight   = 8'h38;
  localparam logic [ByteW-1:0] ByteA       = 8'h41;
  localparam logic [ByteW-1:0] ByteB       = 8'h42;
  localparam logic [ByteW-1:0] ByteC       = 8'h43;
  localparam logic [ByteW-1:0] ByteD       = 8'h44;
  localparam logic [ByteW-1:0] ByteF       = 8'h46;
  localparam logic [ByteW-1:0] ByteH       = 8'h48;
  localparam logic [ByteW-1:0] ByteP       = 8'h50;
  localparam logic [ByteW-1:0] ByteQ       = 8'h51;
  localparam logic [ByteW-1:0] ByteR       = 8'h52;

  // Input command codes.
  localparam logic CmdByte = 1'b0;
  localparam logic CmdGap  = 1'b1;

  // Key codes.
  localparam logic [KeyW-1:0] KeyEsc    = 9'd27;
  localparam logic [KeyW-1:0] KeyUp     = 9'd256;
  localparam logic [KeyW-1:0] KeyDown   = 9'd257;
  localparam logic [KeyW-1:0] KeyRight  = 9'd258;
  localparam logic [KeyW-1:0] KeyLeft   = 9'd259;
  localparam logic [KeyW-1:0] KeyHome   = 9'd260;
  localparam logic [KeyW-1:0] KeyEnd    = 9'd261;
  localparam logic [KeyW-1:0] KeyDelete = 9'd262;
  localparam logic [KeyW-1:0] KeyPgUp   = 9'd263;
  localparam logic [KeyW-1:0] KeyPgDn   = 9'd264;
  localparam logic [KeyW-1:0] KeyF1     = 9'd265;
  localparam logic [KeyW-1:0] KeyF2     = 9'd266;
  localparam logic [KeyW-1:0] KeyF3     = 9'd267;
  localparam logic [KeyW-1:0] KeyF10    = 9'd268;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ESC    = 3'd1,
    PH_PREFIX = 3'd2,
    PH_DIGIT  = 3'd3,
    PH_TWO    = 3'd4
  } phase_t;

  // Result of decoding one item.
  typedef struct packed {
    logic            emit;
    logic [KeyW-1:0] key;
  } dec_res_t;

  function automatic logic is_digit(input logic [ByteW-1:0] b);
    return (b >= ByteZero) && (b <= ByteNine);
  endfunction

  // Final byte of ESC [ x or ESC O x.
  function automatic logic [KeyW-1:0] letter_key(input logic [ByteW-1:0] prefix,
                                                 input logic [ByteW-1:0] b);
    logic [KeyW-1:0] k;
    k = KeyEsc;
    if (prefix == ByteBracket) begin
      case (b)
        ByteA:   k = KeyUp;
        ByteB:   k = KeyDown;
        ByteC:   k = KeyRight;
        ByteD:   k = KeyLeft;
        ByteH:   k = KeyHome;
        ByteF:   k = KeyEnd;
        default: k = KeyEsc;
      endcase
    end else if (prefix == ByteLetterO) begin
      case (b)
        ByteH:   k = KeyHome;
        ByteF:   k = KeyEnd;
        ByteP:   k = KeyF1;
        ByteQ:   k = KeyF2;
        ByteR:   k = KeyF3;
        default: k = KeyEsc;
      endcase
    end
    return k;
  endfunction

  // ESC [ digit ~.
  function automatic logic [KeyW-1:0] one_digit_key(input logic [ByteW-1:0] d);
    logic [KeyW-1:0] k;
    case (d)
      ByteOne:   k = KeyHome;
      ByteThree: k = KeyDelete;
      ByteFour:  k = KeyEnd;
      ByteFive:  k = KeyPgUp;
      ByteSix:   k = KeyPgDn;
      ByteSeven: k = KeyHome;
      ByteEight: k = KeyEnd;
      default:   k = KeyEsc;
    endcase
    return k;
  endfunction

  // ESC [ digit digit ~.
  function automatic logic [KeyW-1:0] two_digit_key(input logic [ByteW-1:0] d1,
                                                    input logic [ByteW-1:0] d2);
    logic [KeyW-1:0] k;
    k = KeyEsc;
    if (d1 == ByteTwo && d2 == ByteOne) begin
      k = KeyF10;
    end else if (d1 == ByteOne && d2 == ByteOne) begin
      k = KeyF1;
    end else if (d1 == ByteOne && d2 == ByteTwo) begin
      k = KeyF2;
    end else if (d1 == ByteOne && d2 == ByteThree) begin
      k = KeyF3;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/esk_fsm.sv =====
// ----------------------------------------------------------------------------
// esk_fsm
// Sequence parser: holds the phase, prefix and first digit, and decodes one
// registered item into at most one key code per step.
// ----------------------------------------------------------------------------
`default_nettype none

module esk_fsm (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step,
  input  wire logic                      cmd,
  input  wire logic [esk_pkg::ByteW-1:0] data_byte,
  output esk_pkg::dec_res_t              res
);
  import esk_pkg::*;

  phase_t           phase_r,  phase_nxt;
  logic [ByteW-1:0] prefix_r, prefix_nxt;
  logic [ByteW-1:0] digit_r,  digit_nxt;

  logic b_digit;
  logic br_digit;
  logic two_dig;

  assign b_digit  = is_digit(data_byte);
  assign br_digit = (prefix_r == ByteBracket) && b_digit;
  assign two_dig  = ((digit_r == ByteOne) || (digit_r == ByteTwo)) && b_digit;

  // Next phase.
  always_comb begin
    phase_nxt = PH_IDLE;
    if (cmd == CmdByte) begin
      case (phase_r)
        PH_IDLE:   phase_nxt = (data_byte == ByteEsc) ? PH_ESC : PH_IDLE;
        PH_ESC:    phase_nxt = PH_PREFIX;
        PH_PREFIX: phase_nxt = br_digit ? PH_DIGIT : PH_IDLE;
        PH_DIGIT:  phase_nxt = two_dig ? PH_TWO : PH_IDLE;
        PH_TWO:    phase_nxt = PH_IDLE;
        default:   phase_nxt = (data_byte == ByteEsc) ? PH_ESC : PH_IDLE;
      endcase
    end
  end

  // Result and the captured bytes.
  always_comb begin
    res.emit   = 1'b0;
    res.key    = KeyEsc;
    prefix_nxt = prefix_r;
    digit_nxt  = digit_r;
    if (cmd == CmdGap) begin
      // A gap closes an open sequence with the escape key.
      case (phase_r)
        PH_ESC, PH_PREFIX, PH_DIGIT, PH_TWO: res.emit = 1'b1;
        default:                             res.emit = 1'b0;
      endcase
    end else begin
      case (phase_r)
        PH_ESC: begin
          prefix_nxt = data_byte;
        end
        PH_PREFIX: begin
          if (br_digit) begin
            digit_nxt = data_byte;
          end else begin
            res.emit = 1'b1;
            res.key  = letter_key(prefix_r, data_byte);
          end
        end
        PH_DIGIT: begin
          if (two_dig) begin
            prefix_nxt = data_byte;
          end else begin
            res.emit = 1'b1;
            res.key  = (data_byte == ByteTilde) ? one_digit_key(digit_r) : KeyEsc;
          end
        end
        PH_TWO: begin
          res.emit = 1'b1;
          res.key  = (data_byte == ByteTilde) ? two_digit_key(digit_r, prefix_r)
                                              : KeyEsc;
        end
        default: begin
          // Idle: plain bytes pass through, escape opens a sequence.
          res.emit = (data_byte != ByteEsc);
          res.key  = {1'b0, data_byte};
        end
      endcase
    end
  end

  // State registers advance once per decoded item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      prefix_r <= '0;
      digit_r  <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      prefix_r <= prefix_nxt;
      digit_r  <= digit_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/escape_sequence_key_decoder.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_key_decoder
// Turns terminal bytes and read gaps into key codes: plain bytes pass
// through, escape sequences become cursor, editing and function keys.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall   in_cmd, in_data_byte
//   out_     output     out_valid/out_stall out_key_code
//
// One item is accepted per clock while in_stall is low. An item is held in the
// input register, is decoded there and lands in the output register, which
// presents the key once the final byte of a sequence has been decoded.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to idle. A stalled output holds the input register; the input
// keeps flowing while the output register is empty or being taken.
`default_nettype none

module escape_sequence_key_decoder (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output      logic                     in_stall,
  input  wire logic                     in_cmd,
  input  wire logic [esk_pkg::ByteW-1:0] in_data_byte,
  output      logic                     out_valid,
  input  wire logic                     out_stall,
  output      logic [esk_pkg::KeyW-1:0] out_key_code
);
  import esk_pkg::*;

  logic             in_vld_r;
  logic             in_cmd_r;
  logic [ByteW-1:0] in_byte_r;
  logic             out_vld_r, out_vld_nxt;
  logic [KeyW-1:0]  out_key_r;
  logic             adv;
  dec_res_t         res;

  // The registered item is decoded when the output register can take it.
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;

  esk_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .cmd       (in_cmd_r),
    .data_byte (in_byte_r),
    .res       (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_cmd_r  <= in_cmd;
      in_byte_r <= in_data_byte;
    end
  end

  // Output register.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = res.emit;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.emit) begin
      out_key_r <= res.key;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_key_code = out_key_r;

endmodule

`default_nettype wire

// ===== sim/escape_sequence_key_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_key_decoder_tb
// Self-checking testbench for the terminal escape sequence key decoder. A
// short directed part covers byte extremes, read gaps and malformed
// sequences. A long random part follows with plain bytes, well-formed key
// sequences of random content, broken ones, gaps and noise. Random idling
// on both channels is used in the random part, except in its last stretch.
// A behavioral parser prediction supplies the expected key of every result.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_key_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import esk_pkg::*;

  // One terminal event as presented on the input channel.
  typedef struct packed {
    logic             cmd;
    logic [ByteW-1:0] data;
  } term_item_t;

  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_stall;
  logic             in_cmd       = CmdByte;
  logic [ByteW-1:0] in_data_byte = '0;
  logic             out_valid;
  logic             out_stall    = 1'b0;
  logic [KeyW-1:0]  out_key_code;

  // Parser state as the prediction sees it.
  phase_t           seq_phase = PH_IDLE;
  logic [ByteW-1:0] seq_lead  = '0;
  logic [ByteW-1:0] seq_digit = '0;

  // Key codes still to come out, oldest first, and the sequence being sent.
  logic [KeyW-1:0]  expected_keys [$];
  term_item_t       seq_items [$];
  logic [KeyW-1:0]  key_want;

  // Final bytes of the bracket and letter-O forms.
  logic [ByteW-1:0] csi_finals [6] = '{ByteA, ByteB, ByteC, ByteD, ByteH, ByteF};
  logic [ByteW-1:0] ss3_finals [5] = '{ByteH, ByteF, ByteP, ByteQ, ByteR};

  bit          tx_gaps_on     = 1'b0;
  bit          rx_stalls_on   = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  int unsigned gaps_sent      = 0;
  int unsigned live_items     = 0;
  int unsigned keys_seen      = 0;
  int unsigned seq_keys_seen  = 0;

  escape_sequence_key_decoder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_key_code (out_key_code)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the mirrored parser by one accepted item and queue its key, if any.
  task automatic decode_expect(input logic cmd, input logic [ByteW-1:0] b);
    logic            emit;
    logic            ignored;
    logic            b_digit;
    logic [KeyW-1:0] key;
    emit    = 1'b1;
    key     = KeyEsc;
    b_digit = (b >= ByteZero) && (b <= ByteNine);
    ignored = (cmd == CmdGap) && (seq_phase == PH_IDLE);
    if (cmd == CmdGap) begin
      emit      = (seq_phase != PH_IDLE);
      seq_phase = PH_IDLE;
    end else begin
      case (seq_phase)
        PH_ESC: begin
          seq_lead  = b;
          seq_phase = PH_PREFIX;
          emit      = 1'b0;
        end
        PH_PREFIX: begin
          if (seq_lead == ByteBracket && b_digit) begin
            seq_digit = b;
            seq_phase = PH_DIGIT;
            emit      = 1'b0;
          end else begin
            seq_phase = PH_IDLE;
            case ({seq_lead, b})
              {ByteBracket, ByteA}: key = KeyUp;
              {ByteBracket, ByteB}: key = KeyDown;
              {ByteBracket, ByteC}: key = KeyRight;
              {ByteBracket, ByteD}: key = KeyLeft;
              {ByteBracket, ByteH}: key = KeyHome;
              {ByteBracket, ByteF}: key = KeyEnd;
              {ByteLetterO, ByteH}: key = KeyHome;
              {ByteLetterO, ByteF}: key = KeyEnd;
              {ByteLetterO, ByteP}: key = KeyF1;
              {ByteLetterO, ByteQ}: key = KeyF2;
              {ByteLetterO, ByteR}: key = KeyF3;
              default:              key = KeyEsc;
            endcase
          end
        end
        PH_DIGIT: begin
          // A leading 1 or 2 may take a second digit before the tilde.
          if ((seq_digit == ByteOne || seq_digit == ByteTwo) && b_digit) begin
            seq_lead  = b;
            seq_phase = PH_TWO;
            emit      = 1'b0;
          end else begin
            seq_phase = PH_IDLE;
            if (b == ByteTilde) begin
              case (seq_digit)
                ByteOne, ByteSeven:  key = KeyHome;
                ByteFour, ByteEight: key = KeyEnd;
                ByteThree:           key = KeyDelete;
                ByteFive:            key = KeyPgUp;
                ByteSix:             key = KeyPgDn;
                default:             key = KeyEsc;
              endcase
            end
          end
        end
        PH_TWO: begin
          seq_phase = PH_IDLE;
          if (b == ByteTilde) begin
            case ({seq_digit, seq_lead})
              {ByteOne, ByteOne}:   key = KeyF1;
              {ByteOne, ByteTwo}:   key = KeyF2;
              {ByteOne, ByteThree}: key = KeyF3;
              {ByteTwo, ByteOne}:   key = KeyF10;
              default:              key = KeyEsc;
            endcase
          end
        end
        default: begin
          if (b == ByteEsc) begin
            seq_phase = PH_ESC;
            emit      = 1'b0;
          end else begin
            key = {1'b0, b};
          end
        end
      endcase
    end
    if (cmd == CmdGap) gaps_sent++;
    else bytes_sent++;
    if (!ignored) live_items++;
    if (emit) expected_keys.push_back(key);
  endtask

  // Offer one item, wait for it to be taken, then maybe idle for a while.
  task automatic push_item(input logic cmd, input logic [ByteW-1:0] b);
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    decode_expect(cmd, b);
    if (tx_gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Stop sending until every queued key has come out.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_keys.size() != 0);
  endtask

  function automatic term_item_t item_of(input logic cmd, input logic [ByteW-1:0] b);
    term_item_t it;
    it.cmd  = cmd;
    it.data = b;
    return it;
  endfunction

  task automatic flush_sequence();
    term_item_t it;
    while (seq_items.size() != 0) begin
      it = seq_items.pop_front();
      push_item(it.cmd, it.data);
    end
  endtask

  // Append one well-formed key sequence with random content.
  task automatic queue_key_sequence();
    logic [ByteW-1:0] d1;
    logic [ByteW-1:0] d2;
    seq_items.push_back(item_of(CmdByte, ByteEsc));
    case ($urandom_range(0, 3))
      0: begin
        seq_items.push_back(item_of(CmdByte, ByteBracket));
        seq_items.push_back(item_of(CmdByte, csi_finals[$urandom_range(0, 5)]));
      end
      1: begin
        seq_items.push_back(item_of(CmdByte, ByteLetterO));
        seq_items.push_back(item_of(CmdByte, ss3_finals[$urandom_range(0, 4)]));
      end
      2: begin
        d1 = 8'(ByteZero + $urandom_range(0, 9));
        seq_items.push_back(item_of(CmdByte, ByteBracket));
        seq_items.push_back(item_of(CmdByte, d1));
        seq_items.push_back(item_of(CmdByte, ByteTilde));
      end
      default: begin
        // Mostly a second digit of 1 to 3, sometimes any second digit.
        d1 = $urandom_range(0, 1) ? ByteOne : ByteTwo;
        if ($urandom_range(0, 9) < 7) d2 = 8'(ByteOne + $urandom_range(0, 2));
        else d2 = 8'(ByteZero + $urandom_range(0, 9));
        seq_items.push_back(item_of(CmdByte, ByteBracket));
        seq_items.push_back(item_of(CmdByte, d1));
        seq_items.push_back(item_of(CmdByte, d2));
        seq_items.push_back(item_of(CmdByte, ByteTilde));
      end
    endcase
  endtask

  // A key sequence cut short by a gap, or with one byte after the escape replaced.
  task automatic queue_broken_sequence();
    int unsigned cut;
    queue_key_sequence();
    cut = $urandom_range(1, seq_items.size() - 1);
    if ($urandom_range(0, 1) != 0) begin
      while (seq_items.size() > cut) void'(seq_items.pop_back());
      seq_items.push_back(item_of(CmdGap, 8'($urandom)));
    end else begin
      seq_items[cut] = item_of(CmdByte, 8'($urandom));
    end
  endtask

  // Short runs biased toward the bytes that steer the parser.
  task automatic queue_noise();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 6))
        0: seq_items.push_back(item_of(CmdByte, ByteEsc));
        1: seq_items.push_back(item_of(CmdByte, ByteBracket));
        2: seq_items.push_back(item_of(CmdByte, ByteLetterO));
        3: seq_items.push_back(item_of(CmdByte, 8'(ByteZero + $urandom_range(0, 9))));
        4: seq_items.push_back(item_of(CmdByte, ByteTilde));
        5: seq_items.push_back(item_of(CmdGap, 8'($urandom)));
        default: seq_items.push_back(item_of(CmdByte, 8'($urandom)));
      endcase
    end
  endtask

  // Byte extremes, a gap while idle and a gap right after escape.
  task automatic test_plain_and_gap_edges();
    push_item(CmdByte, 8'h00);
    push_item(CmdByte, 8'hFF);
    push_item(CmdGap, 8'hA5);
    push_item(CmdByte, ByteEsc);
    push_item(CmdGap, 8'h5A);
  endtask

  // One good sequence, then the ways a sequence can fail.
  task automatic test_malformed_sequences();
    push_item(CmdByte, ByteEsc);
    push_item(CmdByte, ByteBracket);
    push_item(CmdByte, ByteA);
    // Unknown prefix: the byte after it is still swallowed.
    push_item(CmdByte, ByteEsc);
    push_item(CmdByte, 8'h80);
    push_item(CmdByte, ByteA);
    // Final byte that matches no key.
    push_item(CmdByte, ByteEsc);
    push_item(CmdByte, ByteBracket);
    push_item(CmdByte, 8'h5A);
    // Escape inside a sequence.
    push_item(CmdByte, ByteEsc);
    push_item(CmdByte, ByteEsc);
    push_item(CmdByte, ByteA);
    // Two digits that name no key.
    push_item(CmdByte, ByteEsc);
    push_item(CmdByte, ByteBracket);
    push_item(CmdByte, ByteOne);
    push_item(CmdByte, ByteNine);
    push_item(CmdByte, ByteTilde);
  endtask

  // The sender goes quiet in the middle of a sequence until the output drains.
  task automatic test_paused_sequence();
    push_item(CmdByte, ByteEsc);
    push_item(CmdByte, ByteLetterO);
    hold_until_drained();
    push_item(CmdByte, ByteP);
  endtask

  // Mixed random traffic in segments, each with its own idling; quiet at the end.
  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned seg_end;
    int unsigned pick;
    logic [ByteW-1:0] b;
    goal = live_items + 1250;
    while (live_items < goal) begin
      if (goal - live_items <= 200) begin
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
      end else begin
        tx_gaps_on   = $urandom_range(0, 3) != 0;
        rx_stalls_on = $urandom_range(0, 3) != 0;
      end
      seg_end = live_items + 150;
      while (live_items < seg_end && live_items < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          b = 8'($urandom);
          if (b == ByteEsc) b = ~b;
          seq_items.push_back(item_of(CmdByte, b));
        end else if (pick < 75) begin
          queue_key_sequence();
        end else if (pick < 90) begin
          queue_broken_sequence();
        end else if (pick < 95) begin
          seq_items.push_back(item_of(CmdGap, 8'($urandom)));
        end else begin
          queue_noise();
        end
        flush_sequence();
      end
      if (tx_gaps_on && $urandom_range(0, 1) != 0) hold_until_drained();
    end
  endtask

  // Receiver stalls in random bursts while enabled.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_stalls_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare every accepted key with the oldest one predicted.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_keys.size() == 0) begin
        $error("key_code: no result expected, actual %0d", out_key_code);
        mismatch_count++;
      end else begin
        key_want = expected_keys.pop_front();
        if (out_key_code !== key_want) begin
          $error("key_code: expected %0d, actual %0d", key_want, out_key_code);
          mismatch_count++;
        end
        keys_seen++;
        if (key_want >= KeyUp) seq_keys_seen++;
      end
    end
  end

  // Main sequence of tests.
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_plain_and_gap_edges();
    test_malformed_sequences();
    test_paused_sequence();
    test_random_traffic();
    in_valid     <= 1'b0;
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    while (expected_keys.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Drove %0d bytes and %0d read gaps into the decoder.", bytes_sent, gaps_sent);
    $display("Checked %0d key codes, %0d of them from escape sequences.",
             keys_seen, seq_keys_seen);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $error("run timed out with %0d keys still expected", expected_keys.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
